@@ rtl/pinned_lru_buffer_cache_macros.svh @@
// ----------------------------------------------------------------------------
// pinned lru buffer cache assertion macros
// shared concurrent assertion forms, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef PINNED_LRU_BUFFER_CACHE_MACROS_SVH
`define PINNED_LRU_BUFFER_CACHE_MACROS_SVH

`ifndef SYNTH
// condition holds at every edge outside reset
`define PLC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant violated");
// consequence holds in the cycle after the antecedent
`define PLC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequence violated");
`else
`define PLC_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define PLC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ rtl/plc_pkg.sv @@
// ----------------------------------------------------------------------------
// plc_pkg
// codes, selectors and controller/datapath interface structs
// ----------------------------------------------------------------------------
package plc_pkg;

  // request modes
  localparam logic [2:0] MODE_GET       = 3'd0;
  localparam logic [2:0] MODE_UNPIN     = 3'd1;
  localparam logic [2:0] MODE_DIRTY     = 3'd2;
  localparam logic [2:0] MODE_SYNC_PAGE = 3'd3;
  localparam logic [2:0] MODE_SYNC_ALL  = 3'd4;
  localparam logic [2:0] MODE_FLUSH     = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // register map
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_TOTAL = 2'd0;
  localparam logic [1:0] REG_SCAN  = 2'd1;
  localparam logic [1:0] REG_EVICT = 2'd2;

  localparam logic [31:0] TOTAL_RESET = 32'hFFFF_FFFF;
  localparam logic [4:0]  SCAN_RESET  = 5'd16;
  localparam logic [4:0]  EVICT_RESET = 5'd4;

  typedef enum logic [1:0] {
    SEC_REQ   = 2'd0,
    SEC_RDATA = 2'd1,
    SEC_ZERO  = 2'd2,
    SEC_HELD  = 2'd3
  } sec_sel_t;

  typedef enum logic [1:0] {
    SLOT_ZERO = 2'd0,
    SLOT_CUR  = 2'd1,
    SLOT_HELD = 2'd2
  } slot_sel_t;

  typedef struct packed {
    logic      start;
    logic      walk_clr;
    logic      rd_issue;
    logic      pos_inc;
    logic      pin_inc;
    logic      pin_dec;
    logic      dirty_set;
    logic      dirty_clr;
    logic      promote;
    logic      clean_step;
    logic      insert;
    logic      set_stale;
    logic      hold_write;
    logic      emit;
    logic [1:0] emit_kind;
    sec_sel_t  emit_sec;
    slot_sel_t emit_slot;
    logic [1:0] emit_status;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       pos_end;
    logic       range_bad;
    logic       match;
    logic       cur_dirty;
    logic       stale_rd;
    logic       full;
    logic       clean_go;
    logic       stale;
    logic       held_valid;
    logic [2:0] req_mode;
  } sts_t;

endpackage

@@ rtl/pinned_lru_buffer_cache.sv @@
// Operation: a get walks the recency order to find its sector; a full miss adds
// a bounded cleanup scan; sync all and flush walk every entry, and flush then
// purges the unpinned entries when no dirty entry was stale.
// Requests: one at a time, accepted only while the sequencer is idle.
// Reset: synchronous, clears the table and recency order at once, no clearing pass.
// ----------------------------------------------------------------------------
// pinned_lru_buffer_cache
// metadata engine of a sector buffer cache with pin counts and lru order
// ----------------------------------------------------------------------------
module pinned_lru_buffer_cache #(
  parameter int CAPACITY = 16,
  parameter int PIN_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [plc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [2:0]                 mode,
  input  logic [31:0]                sector,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 kind,
  output logic [31:0]                sector_out,
  output logic [3:0]                 slot,
  output logic [1:0]                 status,
  output logic                       last
);
  import plc_pkg::*;

  logic [31:0] sector_limit;
  logic [4:0]  scan_limit, evict_limit;
  cmd_t        cmd;
  sts_t        sts;

  // configuration registers
  plc_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sector_limit (sector_limit),
    .scan_limit   (scan_limit),
    .evict_limit  (evict_limit)
  );

  // sequencer
  plc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table and result path
  plc_datapath #(
    .CAPACITY (CAPACITY),
    .PIN_BITS (PIN_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (mode),
    .in_sector    (sector),
    .sector_limit (sector_limit),
    .scan_limit   (scan_limit),
    .evict_limit  (evict_limit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .sector_out   (sector_out),
    .slot         (slot),
    .status       (status),
    .last         (last)
  );

endmodule

@@ rtl/plc_ram.sv @@
// ----------------------------------------------------------------------------
// plc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module plc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/plc_regs.sv @@
// ----------------------------------------------------------------------------
// plc_regs
// apb configuration registers: sector bound, scan and evict limits
// ----------------------------------------------------------------------------
module plc_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [plc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [31:0]               sector_limit,
  output logic [4:0]                scan_limit,
  output logic [4:0]                evict_limit
);
  import plc_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_limit <= TOTAL_RESET;
      scan_limit   <= SCAN_RESET;
      evict_limit  <= EVICT_RESET;
    end else if (wr) begin
      case (idx)
        REG_TOTAL: sector_limit <= pwdata;
        REG_SCAN:  scan_limit   <= pwdata[4:0];
        REG_EVICT: evict_limit  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_TOTAL: prdata = sector_limit;
      REG_SCAN:  prdata = {27'd0, scan_limit};
      REG_EVICT: prdata = {27'd0, evict_limit};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/plc_datapath.sv @@
// ----------------------------------------------------------------------------
// plc_datapath
// entry table, recency order, sector ram, walk counters and result register
// ----------------------------------------------------------------------------
`include "pinned_lru_buffer_cache_macros.svh"

module plc_datapath #(
  parameter int CAPACITY = 16,
  parameter int PIN_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  plc_pkg::cmd_t cmd,
  output plc_pkg::sts_t sts,
  input  logic [2:0]    in_mode,
  input  logic [31:0]   in_sector,
  input  logic [31:0]   sector_limit,
  input  logic [4:0]    scan_limit,
  input  logic [4:0]    evict_limit,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    kind,
  output logic [31:0]   sector_out,
  output logic [3:0]    slot,
  output logic [1:0]    status,
  output logic          last
);
  import plc_pkg::*;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int LIM_W  = (CNT_W > 5) ? CNT_W : 5;

  logic [SLOT_W-1:0]   rank      [CAPACITY];
  logic [SLOT_W-1:0]   rank_next [CAPACITY];
  logic [CAPACITY-1:0] valid, dirty;
  logic [PIN_BITS-1:0] pins [CAPACITY];
  logic [CNT_W-1:0]    count, pos, seen, gone;
  logic [SLOT_W-1:0]   cur, held_slot;
  logic [31:0]         held_sector, req_sector;
  logic [2:0]          req_mode;
  logic                stale, held_valid;

  logic [SLOT_W-1:0]   pos_idx, cnt_idx, pos_slot, cnt_slot, shift_at;
  logic [31:0]         rdata;
  logic                pos_pins_zero, evict_now, flush_mode;
  logic [LIM_W-1:0]    lim_examine, lim_evict;

  assign pos_idx       = pos[SLOT_W-1:0];
  assign cnt_idx       = count[SLOT_W-1:0];
  assign pos_slot      = rank[pos_idx];
  assign cnt_slot      = rank[cnt_idx];
  assign pos_pins_zero = (pins[pos_slot] == '0);
  assign evict_now     = cmd.clean_step & pos_pins_zero;
  assign flush_mode    = (req_mode == MODE_FLUSH);
  assign lim_examine   = flush_mode ? LIM_W'(CAPACITY) : LIM_W'(scan_limit);
  assign lim_evict     = flush_mode ? LIM_W'(CAPACITY) : LIM_W'(evict_limit);

  // sector store
  plc_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_sector_ram (
    .clk     (clk),
    .wr_en   (cmd.insert),
    .wr_addr (cnt_slot),
    .wr_data (req_sector),
    .rd_en   (cmd.rd_issue),
    .rd_addr (pos_slot),
    .rd_data (rdata)
  );

  // status toward the controller
  always_comb begin
    sts.out_free   = ~out_valid | out_ready;
    sts.pos_end    = (pos >= count);
    sts.range_bad  = (req_sector >= sector_limit);
    sts.match      = valid[cur] & (rdata == req_sector);
    sts.cur_dirty  = valid[cur] & dirty[cur];
    sts.stale_rd   = (rdata >= sector_limit);
    sts.full       = (count == CNT_W'(CAPACITY));
    sts.clean_go   = (pos < count) && (LIM_W'(seen) < lim_examine) &&
                     (LIM_W'(gone) < lim_evict);
    sts.stale      = stale;
    sts.held_valid = held_valid;
    sts.req_mode   = req_mode;
  end

  // recency order: move to front, or close the gap of an evicted position
  assign shift_at = cmd.insert ? cnt_idx : pos_idx;
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      rank_next[i] = rank[i];
    end
    if (cmd.promote || cmd.insert) begin
      rank_next[0] = rank[shift_at];
      for (int i = 1; i < CAPACITY; i++) begin
        if (SLOT_W'(i) <= shift_at) begin
          rank_next[i] = rank[i-1];
        end
      end
    end else if (evict_now) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (SLOT_W'(i) >= pos_idx) begin
          rank_next[i] = rank[i+1];
        end
      end
      rank_next[CAPACITY-1] = pos_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) begin
        rank[i] <= SLOT_W'(i);
      end
    end else begin
      rank <= rank_next;
    end
  end

  // entry flags, pin counts and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      dirty <= '0;
      count <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        pins[i] <= '0;
      end
    end else begin
      if (evict_now) begin
        valid[pos_slot] <= 1'b0;
        dirty[pos_slot] <= 1'b0;
        pins[pos_slot]  <= '0;
        count           <= CNT_W'(count - 1'b1);
      end
      if (cmd.insert) begin
        valid[cnt_slot] <= 1'b1;
        dirty[cnt_slot] <= 1'b0;
        pins[cnt_slot]  <= PIN_BITS'(1);
        count           <= CNT_W'(count + 1'b1);
      end
      if (cmd.pin_inc && pins[cur] != '1) begin
        pins[cur] <= PIN_BITS'(pins[cur] + 1'b1);
      end
      if (cmd.pin_dec && pins[cur] != '0) begin
        pins[cur] <= PIN_BITS'(pins[cur] - 1'b1);
      end
      if (cmd.dirty_set) begin
        dirty[cur] <= 1'b1;
      end
      if (cmd.dirty_clr) begin
        dirty[cur] <= 1'b0;
      end
    end
  end

  // walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      seen <= '0;
      gone <= '0;
    end else if (cmd.start || cmd.walk_clr) begin
      pos  <= '0;
      seen <= '0;
      gone <= '0;
    end else if (cmd.clean_step) begin
      seen <= CNT_W'(seen + 1'b1);
      if (pos_pins_zero) begin
        gone <= CNT_W'(gone + 1'b1);
      end else begin
        pos <= CNT_W'(pos + 1'b1);
      end
    end else if (cmd.pos_inc) begin
      pos <= CNT_W'(pos + 1'b1);
    end
  end

  // request and walk flags
  always_ff @(posedge clk) begin
    if (rst) begin
      stale      <= 1'b0;
      held_valid <= 1'b0;
      req_mode   <= MODE_GET;
    end else if (cmd.start) begin
      stale      <= 1'b0;
      held_valid <= 1'b0;
      req_mode   <= in_mode;
    end else begin
      if (cmd.set_stale) begin
        stale <= 1'b1;
      end
      if (cmd.hold_write) begin
        held_valid <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_sector <= in_sector;
    end
    if (cmd.rd_issue) begin
      cur <= pos_slot;
    end else if (cmd.insert) begin
      cur <= cnt_slot;
    end
    if (cmd.hold_write) begin
      held_sector <= rdata;
      held_slot   <= cur;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind   <= cmd.emit_kind;
      status <= cmd.emit_status;
      last   <= cmd.emit_last;
      case (cmd.emit_sec)
        SEC_REQ:   sector_out <= req_sector;
        SEC_RDATA: sector_out <= rdata;
        SEC_HELD:  sector_out <= held_sector;
        default:   sector_out <= 32'd0;
      endcase
      case (cmd.emit_slot)
        SLOT_CUR:  slot <= 4'(cur);
        SLOT_HELD: slot <= 4'(held_slot);
        default:   slot <= 4'd0;
      endcase
    end
  end

  // table invariants
  `PLC_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(CAPACITY))
  `PLC_ASSERT_ALWAYS(a_valid_count, clk, rst, $countones(valid) == int'(count))
  `PLC_ASSERT_ALWAYS(a_dirty_valid, clk, rst, (dirty & ~valid) == '0)
  `PLC_ASSERT_NEXT(a_insert_grow, clk, rst, cmd.insert, count == CNT_W'($past(count) + 1'b1))

endmodule

@@ rtl/plc_ctrl.sv @@
// ----------------------------------------------------------------------------
// plc_ctrl
// request sequencer: lookup walk, cleanup scan, sync walk and result emission
// ----------------------------------------------------------------------------
module plc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  plc_pkg::sts_t sts,
  output plc_pkg::cmd_t cmd
);
  import plc_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_DECODE    = 13'b0000000000010,
    S_FIND_RD   = 13'b0000000000100,
    S_FIND_CMP  = 13'b0000000001000,
    S_HIT       = 13'b0000000010000,
    S_CLEAN     = 13'b0000000100000,
    S_INSERT    = 13'b0000001000000,
    S_EMIT_READ = 13'b0000010000000,
    S_SYNC_RD   = 13'b0000100000000,
    S_SYNC_CMP  = 13'b0001000000000,
    S_PURGE     = 13'b0010000000000,
    S_FINAL     = 13'b0100000000000,
    S_EMIT_HELD = 13'b1000000000000
  } state_t;

  state_t     state, state_next;
  sec_sel_t   fin_sec, fin_sec_next;
  slot_sel_t  fin_slot, fin_slot_next;
  logic [1:0] fin_status, fin_status_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fin_sec    <= SEC_REQ;
      fin_slot   <= SLOT_ZERO;
      fin_status <= ST_OK;
    end else begin
      state      <= state_next;
      fin_sec    <= fin_sec_next;
      fin_slot   <= fin_slot_next;
      fin_status <= fin_status_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    fin_sec_next    = fin_sec;
    fin_slot_next   = fin_slot;
    fin_status_next = fin_status;
    cmd             = '0;
    cmd.emit_sec    = SEC_REQ;
    cmd.emit_slot   = SLOT_ZERO;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        fin_sec_next    = SEC_REQ;
        fin_slot_next   = SLOT_ZERO;
        fin_status_next = ST_OK;
        case (sts.req_mode)
          MODE_GET: begin
            if (sts.range_bad) begin
              fin_status_next = ST_RANGE;
              state_next      = S_FINAL;
            end else begin
              state_next = S_FIND_RD;
            end
          end
          MODE_UNPIN, MODE_DIRTY, MODE_SYNC_PAGE: state_next = S_FIND_RD;
          MODE_SYNC_ALL, MODE_FLUSH:              state_next = S_SYNC_RD;
          default:                                state_next = S_FINAL;
        endcase
      end
      // lookup walk, reading then comparing one table position at a time
      S_FIND_RD: begin
        if (sts.pos_end) begin
          if (sts.req_mode == MODE_GET) begin
            cmd.walk_clr = 1'b1;
            state_next   = sts.full ? S_CLEAN : S_INSERT;
          end else begin
            fin_status_next = ST_MISS;
            state_next      = S_FINAL;
          end
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (sts.match) begin
          state_next = S_HIT;
        end else begin
          cmd.pos_inc = 1'b1;
          state_next  = S_FIND_RD;
        end
      end
      S_HIT: begin
        fin_slot_next = SLOT_CUR;
        case (sts.req_mode)
          MODE_GET: begin
            cmd.pin_inc = 1'b1;
            cmd.promote = 1'b1;
            state_next  = S_FINAL;
          end
          MODE_UNPIN: begin
            cmd.pin_dec = 1'b1;
            state_next  = S_FINAL;
          end
          MODE_DIRTY: begin
            cmd.dirty_set = 1'b1;
            state_next    = S_FINAL;
          end
          default: begin
            // sync page writes a dirty in-range entry first
            if (!sts.cur_dirty) begin
              state_next = S_FINAL;
            end else if (sts.stale_rd) begin
              fin_status_next = ST_RANGE;
              state_next      = S_FINAL;
            end else if (sts.out_free) begin
              cmd.emit        = 1'b1;
              cmd.emit_kind   = KIND_WRITE;
              cmd.emit_slot   = SLOT_CUR;
              cmd.emit_status = ST_OK;
              cmd.dirty_clr   = 1'b1;
              state_next      = S_FINAL;
            end
          end
        endcase
      end
      // bounded cleanup scan on a full miss
      S_CLEAN: begin
        if (sts.clean_go) begin
          cmd.clean_step = 1'b1;
        end else if (sts.full) begin
          fin_status_next = ST_FULL;
          state_next      = S_FINAL;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_EMIT_READ;
      end
      S_EMIT_READ: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_READ;
          cmd.emit_slot   = SLOT_CUR;
          cmd.emit_status = ST_OK;
          fin_slot_next   = SLOT_CUR;
          state_next      = S_FINAL;
        end
      end
      // sync walk over the table in recency order
      S_SYNC_RD: begin
        if (sts.pos_end) begin
          fin_sec_next = SEC_ZERO;
          if (sts.req_mode == MODE_SYNC_ALL) begin
            fin_status_next = sts.stale ? ST_RANGE : ST_OK;
            state_next      = S_FINAL;
          end else if (sts.stale) begin
            fin_status_next = ST_RANGE;
            state_next      = S_FINAL;
          end else begin
            cmd.walk_clr = 1'b1;
            state_next   = S_PURGE;
          end
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_SYNC_CMP;
        end
      end
      S_SYNC_CMP: begin
        if (!sts.cur_dirty) begin
          cmd.pos_inc = 1'b1;
          state_next  = S_SYNC_RD;
        end else if (sts.stale_rd) begin
          cmd.set_stale = 1'b1;
          cmd.pos_inc   = 1'b1;
          state_next    = S_SYNC_RD;
        end else if (sts.req_mode == MODE_SYNC_ALL && !sts.held_valid) begin
          // sync all sends its first write after the final status
          cmd.hold_write = 1'b1;
          cmd.dirty_clr  = 1'b1;
          cmd.pos_inc    = 1'b1;
          state_next     = S_SYNC_RD;
        end else if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_WRITE;
          cmd.emit_sec    = SEC_RDATA;
          cmd.emit_slot   = SLOT_CUR;
          cmd.emit_status = ST_OK;
          cmd.dirty_clr   = 1'b1;
          cmd.pos_inc     = 1'b1;
          state_next      = S_SYNC_RD;
        end
      end
      // flush evicts every unpinned entry
      S_PURGE: begin
        if (sts.clean_go) begin
          cmd.clean_step = 1'b1;
        end else begin
          fin_status_next = ST_OK;
          state_next      = S_FINAL;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_FINAL;
          cmd.emit_sec    = fin_sec;
          cmd.emit_slot   = fin_slot;
          cmd.emit_status = fin_status;
          cmd.emit_last   = 1'b1;
          if (sts.req_mode == MODE_SYNC_ALL && sts.held_valid) begin
            state_next = S_EMIT_HELD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_EMIT_HELD: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_kind   = KIND_WRITE;
          cmd.emit_sec    = SEC_HELD;
          cmd.emit_slot   = SLOT_HELD;
          cmd.emit_status = ST_OK;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ dv/plc_checker.sv @@
// ----------------------------------------------------------------------------
// plc_checker
// watches the request and result channels and the register port, keeps its
// own copy of the cache table and recency order, predicts the result items of
// every accepted request and compares them field by field in order
// ----------------------------------------------------------------------------
module plc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [plc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [31:0] sector,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] sector_out,
  input  logic [3:0]  slot,
  input  logic [1:0]  status,
  input  logic        last,
  output int          n_errors,
  output int          n_pending
);
  import plc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam logic [15:0] PIN_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sec;
    logic [3:0]  slot;
    logic [1:0]  status;
    logic        last;
  } result_t;

  // shadow copy of the cache state and registers
  logic [31:0] limit_sec;
  logic [4:0]  scan_cnt;
  logic [4:0]  evict_cnt;
  logic        ent_valid [NSLOT];
  logic [31:0] ent_sec [NSLOT];
  logic        ent_dirty [NSLOT];
  logic [15:0] ent_pins [NSLOT];
  logic [3:0]  lru_order [NSLOT];
  int          used;

  result_t expected_results[$];

  assign n_pending = expected_results.size();

  function automatic int lookup(logic [31:0] sec);
    for (int p = 0; p < used; p++)
      if (ent_valid[lru_order[p]] && ent_sec[lru_order[p]] == sec) return p;
    return -1;
  endfunction

  function automatic void move_front(int p);
    logic [3:0] s;
    s = lru_order[p];
    for (int i = p; i > 0; i--) lru_order[i] = lru_order[i-1];
    lru_order[0] = s;
  endfunction

  function automatic void drop_at(int p);
    logic [3:0] s;
    s = lru_order[p];
    for (int i = p; i + 1 < NSLOT; i++) lru_order[i] = lru_order[i+1];
    lru_order[NSLOT-1] = s;
    ent_valid[s] = 0;
    ent_dirty[s] = 0;
    ent_pins[s] = 0;
    if (used > 0) used--;
  endfunction

  function automatic void purge(int examine, int max_gone);
    int p, seen, gone;
    p = 0; seen = 0; gone = 0;
    while (p < used && seen < examine && gone < max_gone) begin
      if (ent_pins[lru_order[p]] == 0) begin
        drop_at(p);
        gone++;
      end else begin
        p++;
      end
      seen++;
    end
  endfunction

  function automatic void push(logic [1:0] k, logic [31:0] sec, logic [3:0] sl,
                               logic [1:0] st, logic lst);
    result_t r;
    r.kind = k; r.sec = sec; r.slot = sl; r.status = st; r.last = lst;
    expected_results.push_back(r);
  endfunction

  // write back dirty in-range entries in recency order; 1 if one was stale
  function automatic bit write_back_all();
    bit stale;
    logic [3:0] s;
    stale = 0;
    for (int p = 0; p < used; p++) begin
      s = lru_order[p];
      if (ent_valid[s] && ent_dirty[s]) begin
        if (ent_sec[s] >= limit_sec) begin
          stale = 1;
        end else begin
          push(KIND_WRITE, ent_sec[s], s, ST_OK, 1'b0);
          ent_dirty[s] = 0;
        end
      end
    end
    return stale;
  endfunction

  function automatic void predict_request(logic [2:0] md, logic [31:0] sec);
    int p;
    logic [3:0] s;
    int n0;
    bit stale;
    result_t first_wr;
    case (md)
      MODE_GET: begin
        if (sec >= limit_sec) begin
          push(KIND_FINAL, sec, 4'd0, ST_RANGE, 1'b1);
          return;
        end
        p = lookup(sec);
        if (p >= 0) begin
          s = lru_order[p];
          if (ent_pins[s] < PIN_MAX) ent_pins[s]++;
          move_front(p);
          push(KIND_FINAL, sec, s, ST_OK, 1'b1);
          return;
        end
        if (used >= NSLOT) begin
          purge(scan_cnt, evict_cnt);
          if (used >= NSLOT) begin
            push(KIND_FINAL, sec, 4'd0, ST_FULL, 1'b1);
            return;
          end
        end
        move_front(used);
        s = lru_order[0];
        ent_valid[s] = 1;
        ent_sec[s] = sec;
        ent_dirty[s] = 0;
        ent_pins[s] = 1;
        used++;
        push(KIND_READ, sec, s, ST_OK, 1'b0);
        push(KIND_FINAL, sec, s, ST_OK, 1'b1);
      end
      MODE_UNPIN, MODE_DIRTY, MODE_SYNC_PAGE: begin
        p = lookup(sec);
        if (p < 0) begin
          push(KIND_FINAL, sec, 4'd0, ST_MISS, 1'b1);
          return;
        end
        s = lru_order[p];
        if (md == MODE_UNPIN) begin
          if (ent_pins[s] > 0) ent_pins[s]--;
        end else if (md == MODE_DIRTY) begin
          ent_dirty[s] = 1;
        end else if (ent_dirty[s]) begin
          if (ent_sec[s] >= limit_sec) begin
            push(KIND_FINAL, sec, s, ST_RANGE, 1'b1);
            return;
          end
          push(KIND_WRITE, ent_sec[s], s, ST_OK, 1'b0);
          ent_dirty[s] = 0;
        end
        push(KIND_FINAL, sec, s, ST_OK, 1'b1);
      end
      MODE_SYNC_ALL: begin
        // the first write goes out after the final status
        n0 = expected_results.size();
        stale = write_back_all();
        push(KIND_FINAL, 32'd0, 4'd0, stale ? ST_RANGE : ST_OK, 1'b1);
        if (expected_results.size() - n0 > 1) begin
          first_wr = expected_results[n0];
          expected_results.delete(n0);
          expected_results.push_back(first_wr);
        end
      end
      MODE_FLUSH: begin
        if (write_back_all()) begin
          push(KIND_FINAL, 32'd0, 4'd0, ST_RANGE, 1'b1);
        end else begin
          purge(NSLOT, NSLOT);
          push(KIND_FINAL, 32'd0, 4'd0, ST_OK, 1'b1);
        end
      end
      default: begin
        push(KIND_FINAL, sec, 4'd0, ST_OK, 1'b1);
      end
    endcase
  endfunction

  // shadow update, prediction and comparison
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      limit_sec <= TOTAL_RESET;
      scan_cnt <= SCAN_RESET;
      evict_cnt <= EVICT_RESET;
      for (int i = 0; i < NSLOT; i++) begin
        ent_valid[i] = 0;
        ent_sec[i] = 0;
        ent_dirty[i] = 0;
        ent_pins[i] = 0;
        lru_order[i] = i[3:0];
      end
      used = 0;
      n_errors <= 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_TOTAL: limit_sec <= pwdata;
          REG_SCAN:  scan_cnt <= pwdata[4:0];
          REG_EVICT: evict_cnt <= pwdata[4:0];
          default: ;
        endcase
      end
      // compare result item against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (n_errors < 10)
            $display("%0t: unexpected item k=%0d s=%h sl=%0d st=%0d l=%0b",
                     $realtime, kind, sector_out, slot, status, last);
          n_errors <= n_errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.kind !== kind || exp_r.sec !== sector_out || exp_r.slot !== slot ||
              exp_r.status !== status || exp_r.last !== last) begin
            if (n_errors < 10)
              $display("%0t: exp %0d %h %0d %0d %0b got %0d %h %0d %0d %0b",
                       $realtime, exp_r.kind, exp_r.sec, exp_r.slot, exp_r.status,
                       exp_r.last, kind, sector_out, slot, status, last);
            n_errors <= n_errors + 1;
          end
        end
      end
      // predict on request accept
      if (in_valid && in_ready) predict_request(mode, sector);
    end
  end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// drives requests and register writes into the buffer cache engine through
// several register settings, with random idling on both channels
// ----------------------------------------------------------------------------
module tb;
  import plc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready;
  logic [2:0] mode;
  logic [31:0] sector;
  logic out_valid, out_ready;
  logic [1:0] kind, status;
  logic [31:0] sector_out;
  logic [3:0] slot;
  logic last;
  int n_errors, n_pending;
  bit idle_on;

  // small working set of sector numbers so hits and full misses happen
  logic [31:0] pool [24];

  pinned_lru_buffer_cache dut (.*);

  plc_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver stalls in bursts
  initial begin
    int burst;
    out_ready = 0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 7);
        out_ready <= 0;
        repeat (burst) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send_request(logic [2:0] md, logic [31:0] sec);
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 7)) @(posedge clk);
    in_valid <= 1; mode <= md; sector <= sec;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 0;
    @(posedge clk);
  endtask

  // wait until every expected result is in, then let the block settle
  task automatic drain();
    while (n_pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sector();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      default: return pool[$urandom_range(0, 23)];
    endcase
  endfunction

  function automatic logic [2:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return MODE_GET;
    if (r < 65) return MODE_UNPIN;
    if (r < 78) return MODE_DIRTY;
    if (r < 88) return MODE_SYNC_PAGE;
    if (r < 93) return MODE_SYNC_ALL;
    if (r < 97) return MODE_FLUSH;
    return 3'($urandom_range(6, 7));
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_request(pick_mode(), pick_sector());
  endtask

  initial begin
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; mode = '0; sector = '0; idle_on = 1;
    for (int i = 0; i < 24; i++) pool[i] = $urandom();
    pool[0] = 32'd0;
    pool[1] = 32'hFFFF_FFFE;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: fill the table, hits, every mode but flush, special cases
    send_request(MODE_UNPIN, 32'd5);
    send_request(MODE_GET, 32'hFFFF_FFFF);
    for (int i = 0; i < 16; i++) send_request(MODE_GET, pool[i]);
    send_request(MODE_GET, pool[0]);
    send_request(MODE_DIRTY, pool[1]);
    send_request(MODE_SYNC_PAGE, pool[1]);
    send_request(MODE_GET, pool[20]);
    send_request(3'd6, 32'hA5A5_5A5A);
    send_request(3'd7, 32'h5A5A_A5A5);
    send_request(MODE_SYNC_ALL, 32'd0);
    drain();

    // full misses with pinned table, then unpin some
    reg_write(REG_SCAN, 32'd1);
    reg_write(REG_EVICT, 32'd16);
    reg_write(REG_TOTAL, 32'hFFFF_FFFF);
    random_phase(30);
    drain();

    // wider scan, single evict: unpin the first sixteen pool sectors, then random requests
    reg_write(REG_SCAN, 32'd16);
    reg_write(REG_EVICT, 32'd1);
    for (int i = 0; i < 16; i++) send_request(MODE_UNPIN, pool[i]);
    random_phase(25);
    drain();

    // lowered range: stale dirty entries on write
    for (int i = 0; i < 8; i++) send_request(MODE_DIRTY, pool[i]);
    drain();
    reg_write(REG_TOTAL, 32'd1);
    send_request(MODE_SYNC_PAGE, pool[1]);
    send_request(MODE_SYNC_ALL, 32'd0);
    send_request(MODE_FLUSH, 32'd0);
    send_request(MODE_GET, 32'd0);
    random_phase(20);
    drain();

    reg_write(REG_TOTAL, 32'h8000_0000);
    reg_write(REG_SCAN, 32'd0);
    reg_write(REG_EVICT, 32'd0);
    random_phase(30);
    drain();
    reg_write(REG_SCAN, 32'd8);
    reg_write(REG_EVICT, 32'd3);
    reg_write(REG_TOTAL, 32'hFFFF_FFFF);
    send_request(MODE_FLUSH, 32'd0);
    random_phase(25);

    // tail with no idling
    idle_on = 0;
    random_phase(30);
    send_request(MODE_FLUSH, 32'd0);
    drain();
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
